FILE: src/rsmv_pkg.sv
// shared constants and types for the row sum / mean / variance block
// no dependencies
package rsmv_pkg;

   localparam int OUT_BITS = 48;
   localparam int CORR_BITS = 12;
   localparam int MODE_BITS = 2;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [MODE_BITS-1:0] MODE_SUM  = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_MEAN = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_VAR  = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_STAT_MODE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DOF_CORR  = 2'd1;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_MULQ = 6'b000010,
      ST_MULS = 6'b000100,
      ST_MULD = 6'b001000,
      ST_DIV  = 6'b010000,
      ST_OUT  = 6'b100000
   } back_state_type;

endpackage

FILE: src/rsmv_front.sv
// front part: takes samples, accumulates row sum, sum of squares and count
// depends on rsmv_pkg
module rsmv_front
   import rsmv_pkg::*;
#(
   parameter int SAMPLE_BITS = 16,
   parameter int MAX_COLS = 4096,
   parameter int CW = $clog2(MAX_COLS + 1),
   parameter int SW = SAMPLE_BITS + CW,
   parameter int QW = 2 * SAMPLE_BITS + CW
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [SAMPLE_BITS-1:0] in_sample,
   input  logic                   in_last,
   output logic                   in_ready,
   input  logic                   q_full,
   output logic                   q_push,
   output logic [SW+QW+CW-1:0]    q_data
);

   localparam logic [CW-1:0] MAX_N = CW'(MAX_COLS);

   logic signed [SW-1:0] sum_ff, sum_in;
   logic [QW-1:0]        sumsq_ff, sumsq_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic signed [SAMPLE_BITS-1:0]   x;
   logic signed [2*SAMPLE_BITS-1:0] sq;
   logic                 take;

   assign in_ready = !q_full;
   assign take = in_valid && !q_full;
   assign x = signed'(in_sample);
   assign sq = x * x;

   always_comb begin
      sum_in = sum_ff;
      sumsq_in = sumsq_ff;
      cnt_in = cnt_ff;
      if (cnt_ff < MAX_N) begin
         sum_in = sum_ff + SW'(x);
         sumsq_in = sumsq_ff + QW'(unsigned'(sq));
         cnt_in = cnt_ff + 1'b1;
      end
   end

   assign q_push = take && in_last;
   assign q_data = {cnt_in, sumsq_in, sum_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         sumsq_ff <= '0;
         cnt_ff <= '0;
      end else if (take) begin
         if (in_last) begin
            sum_ff <= '0;
            sumsq_ff <= '0;
            cnt_ff <= '0;
         end else begin
            sum_ff <= sum_in;
            sumsq_ff <= sumsq_in;
            cnt_ff <= cnt_in;
         end
      end
   end

endmodule

FILE: src/rsmv_queue.sv
// two-entry queue of finished row totals between front and back
// depends on rsmv_pkg
module rsmv_queue
   import rsmv_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] head_data
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ff, rd_ff;
   logic [1:0]       cnt_ff;

   assign full = cnt_ff == 2'd2;
   assign not_empty = cnt_ff != 2'd0;
   assign head_data = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop) rd_ff <= !rd_ff;
         case ({push, pop})
            2'b10: cnt_ff <= cnt_ff + 2'd1;
            2'b01: cnt_ff <= cnt_ff - 2'd1;
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

endmodule

FILE: src/rsmv_back.sv
// back part: shift-add multiplier and restoring divider form the row statistic
// depends on rsmv_pkg
module rsmv_back
   import rsmv_pkg::*;
#(
   parameter int CW = 13,
   parameter int SW = 29,
   parameter int QW = 45
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [MODE_BITS-1:0]  stat_mode,
   input  logic [CORR_BITS-1:0]  dof_corr,
   input  logic                  q_not_empty,
   input  logic [SW+QW+CW-1:0]   q_data,
   output logic                  q_pop,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [OUT_BITS-1:0]   out_value,
   output logic                  out_error
);

   localparam int PW = QW + CW;
   localparam int DW = 2 * CW;
   localparam int NC = (CW > CORR_BITS) ? CW : CORR_BITS;
   localparam int KW = $clog2(PW + 1);

   back_state_type state_ff;
   logic signed [SW-1:0] sum_ff;
   logic [CW-1:0]   n_ff;
   logic            neg_ff;
   logic [PW-1:0]   a_ff, acc_ff, t1_ff, quo_ff;
   logic [SW-1:0]   b_ff;
   logic [DW-1:0]   div_ff, rem_ff;
   logic [KW-1:0]   k_ff;
   logic signed [PW:0] res_ff;
   logic            err_ff;
   logic            valid_ff;
   logic [OUT_BITS-1:0] value_ff;
   logic            error_ff;

   logic signed [SW-1:0] h_sum;
   logic [QW-1:0]   h_sq;
   logic [CW-1:0]   h_n;
   logic [SW-1:0]   h_mag, s_mag;
   logic [NC-1:0]   n_ext, c_ext, d_ext;
   logic [PW-1:0]   acc_nx;
   logic [DW:0]     r2;
   logic            fit;

   assign {h_n, h_sq, h_sum} = q_data;
   assign h_mag = h_sum[SW-1] ? SW'(-h_sum) : SW'(h_sum);
   assign s_mag = sum_ff[SW-1] ? SW'(-sum_ff) : SW'(sum_ff);
   assign n_ext = NC'(n_ff);
   assign c_ext = NC'(dof_corr);
   assign d_ext = n_ext - c_ext;
   assign acc_nx = acc_ff + (b_ff[0] ? a_ff : '0);
   assign r2 = {rem_ff, quo_ff[PW-1]};
   assign fit = r2 >= {1'b0, div_ff};

   assign q_pop = (state_ff == ST_IDLE) && q_not_empty;
   assign out_valid = valid_ff;
   assign out_value = value_ff;
   assign out_error = error_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         if (out_ready && state_ff != ST_OUT) valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (q_not_empty) begin
                  sum_ff <= h_sum;
                  n_ff <= h_n;
                  err_ff <= (stat_mode == MODE_VAR) && (NC'(h_n) <= c_ext);
                  res_ff <= (stat_mode == MODE_SUM) ? (PW+1)'(h_sum) : '0;
                  acc_ff <= '0;
                  case (stat_mode)
                     MODE_SUM: begin
                        state_ff <= ST_OUT;
                     end
                     MODE_MEAN: begin
                        if (h_n == '0) begin
                           state_ff <= ST_OUT;
                        end else begin
                           quo_ff <= PW'(h_mag);
                           div_ff <= DW'(h_n);
                           rem_ff <= '0;
                           k_ff <= '0;
                           neg_ff <= h_sum[SW-1];
                           state_ff <= ST_DIV;
                        end
                     end
                     MODE_VAR: begin
                        if (NC'(h_n) <= c_ext) begin
                           state_ff <= ST_OUT;
                        end else begin
                           a_ff <= PW'(h_sq);
                           b_ff <= SW'(h_n);
                           neg_ff <= 1'b0;
                           state_ff <= ST_MULQ;
                        end
                     end
                     default: state_ff <= ST_OUT;
                  endcase
               end
            end
            ST_MULQ, ST_MULS, ST_MULD: begin
               if (b_ff == '0) begin
                  acc_ff <= '0;
                  if (state_ff == ST_MULQ) begin
                     t1_ff <= acc_ff;
                     a_ff <= PW'(s_mag);
                     b_ff <= s_mag;
                     state_ff <= ST_MULS;
                  end else if (state_ff == ST_MULS) begin
                     quo_ff <= t1_ff - acc_ff;
                     a_ff <= PW'(n_ff);
                     b_ff <= SW'(d_ext);
                     state_ff <= ST_MULD;
                  end else begin
                     div_ff <= DW'(acc_ff);
                     rem_ff <= '0;
                     k_ff <= '0;
                     state_ff <= ST_DIV;
                  end
               end else begin
                  acc_ff <= acc_nx;
                  a_ff <= {a_ff[PW-2:0], 1'b0};
                  b_ff <= {1'b0, b_ff[SW-1:1]};
               end
            end
            ST_DIV: begin
               if (k_ff == KW'(PW)) begin
                  res_ff <= neg_ff ? -signed'({1'b0, quo_ff}) : signed'({1'b0, quo_ff});
                  state_ff <= ST_OUT;
               end else begin
                  rem_ff <= fit ? DW'(r2 - {1'b0, div_ff}) : DW'(r2);
                  quo_ff <= {quo_ff[PW-2:0], fit};
                  k_ff <= k_ff + 1'b1;
               end
            end
            ST_OUT: begin
               if (!valid_ff || out_ready) begin
                  valid_ff <= 1'b1;
                  value_ff <= OUT_BITS'(res_ff);
                  error_ff <= err_ff;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

FILE: src/row_sum_mean_variance_top.sv
// top level of the row sum / mean / variance block
// depends on rsmv_pkg, rsmv_front, rsmv_queue, rsmv_back
//
//  port group  direction  contents
//  req_        in         tdata sample, tlast row end
//  rsp_        out        tdata stat_value, tuser div_error
//  csr_        in         index 0 stat_mode, index 1 dof_correction
//
// samples are taken one per cycle while the two-entry row queue has room
// from its pop a row result goes straight to the output register in sum mode or on
// a divisor error, passes the divider in mean mode and three multiplies and the
// divider in variance mode; the one-bit-per-cycle multiplier and divider sit in the back part
// a held result stops the back part, then the queue fills and req_tready drops
// reset is synchronous and clears accumulators, queue counts, csr registers and back-part state
module row_sum_mean_variance_top
   import rsmv_pkg::*;
#(
   parameter int SAMPLE_BITS = 16,
   parameter int MAX_COLS = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0] req_tdata,  // sample
   input  logic                          req_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [OUT_BITS-1:0]           rsp_tdata,  // stat_value
   output logic                          rsp_tuser,  // div_error
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CORR_BITS-1:0]          csr_data
);

   localparam int CW = $clog2(MAX_COLS + 1);
   localparam int SW = SAMPLE_BITS + CW;
   localparam int QW = 2 * SAMPLE_BITS + CW;
   localparam int EW = SW + QW + CW;

   logic [MODE_BITS-1:0] mode_ff;
   logic [CORR_BITS-1:0] corr_ff;
   logic          q_full, q_push, q_pop, q_ne;
   logic [EW-1:0] q_in, q_out;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SUM;
         corr_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_STAT_MODE: mode_ff <= csr_data[MODE_BITS-1:0];
            CSR_DOF_CORR:  corr_ff <= csr_data;
            default: ;
         endcase
      end
   end

   rsmv_front #(.SAMPLE_BITS(SAMPLE_BITS), .MAX_COLS(MAX_COLS),
                .CW(CW), .SW(SW), .QW(QW)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_sample(req_tdata[SAMPLE_BITS-1:0]),
      .in_last(req_tlast), .in_ready(req_tready),
      .q_full(q_full), .q_push(q_push), .q_data(q_in)
   );

   rsmv_queue #(.WIDTH(EW)) u_queue (
      .clock(clock), .reset(reset),
      .push(q_push), .push_data(q_in), .full(q_full),
      .pop(q_pop), .not_empty(q_ne), .head_data(q_out)
   );

   rsmv_back #(.CW(CW), .SW(SW), .QW(QW)) u_back (
      .clock(clock), .reset(reset),
      .stat_mode(mode_ff), .dof_corr(corr_ff),
      .q_not_empty(q_ne), .q_data(q_out), .q_pop(q_pop),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_value(rsp_tdata), .out_error(rsp_tuser)
   );

endmodule

FILE: tb/sv/testbench.sv
// self-checking bench for row_sum_mean_variance_top: random rows of signed 16-bit integer samples
// go through every statistic mode and a range of corrections, each row result is checked
// depends on rsmv_pkg and row_sum_mean_variance_top
module testbench;
   import rsmv_pkg::*;

   typedef struct packed {
      logic [15:0] sample;
      logic        row_end;
   } sample_req_type;

   typedef struct packed {
      logic [OUT_BITS-1:0] value;
      logic                err;
   } row_stat_type;

   localparam int LIMIT_CYCLES = 3000000;
   localparam int DRAIN_CYCLES = 400;
   localparam int ROW_CAP = 4096;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [15:0] req_tdata = '0;  // sample
   logic req_tlast = 0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [OUT_BITS-1:0] rsp_tdata;  // stat_value
   logic rsp_tuser;  // div_error
   logic csr_valid = 0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CORR_BITS-1:0] csr_data = '0;

   sample_req_type sample_q[$];
   row_stat_type stat_q[$];
   int errors = 0;
   int cycles = 0;
   bit quiet = 0;
   int hold_requests = 0;

   logic [MODE_BITS-1:0] mode_mirror = MODE_SUM;
   logic [CORR_BITS-1:0] corr_mirror = '0;
   longint row_sum = 0;
   longint unsigned row_sumsq = 0;
   longint unsigned row_count = 0;

   row_sum_mean_variance_top DUT (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic void predict_row_stat(logic [15:0] s, logic last);
      longint x;
      longint unsigned n, c, mag, num, den;
      row_stat_type r;
      x = $signed(s);
      if (row_count < ROW_CAP) begin
         row_sum += x;
         row_sumsq += longint'(x * x);
         row_count++;
      end
      if (!last) return;
      n = row_count;
      c = corr_mirror;
      r = '0;
      case (mode_mirror)
         MODE_SUM: r.value = row_sum[OUT_BITS-1:0];
         MODE_MEAN: r.value = (n != 0) ? OUT_BITS'(row_sum / longint'(n)) : '0;
         MODE_VAR: begin
            if (n <= c) begin
               r.err = 1;
            end else begin
               mag = (row_sum < 0) ? -row_sum : row_sum;
               num = n * row_sumsq - mag * mag;
               den = n * (n - c);
               r.value = OUT_BITS'(num / den);
            end
         end
         default: r = '0;
      endcase
      stat_q.push_back(r);
      row_sum = 0;
      row_sumsq = 0;
      row_count = 0;
   endfunction

   task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      errors++;
   endtask

   // request driver
   int send_gap = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (reset) begin
         req_tvalid <= 0;
      end else begin
         if (req_tvalid && req_tready)
            predict_row_stat(req_tdata, req_tlast);
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_tvalid <= 0;
            end else if (sample_q.size() > 0 && !quiet && $urandom_range(0, 15) == 0) begin
               send_gap <= $urandom_range(1, 9);
               req_tvalid <= 0;
            end else if (sample_q.size() > 0) begin
               sample_req_type it;
               it = sample_q.pop_front();
               req_tvalid <= 1;
               req_tdata <= it.sample;
               req_tlast <= it.row_end;
            end else begin
               req_tvalid <= 0;
            end
         end
      end
   end

   // result monitor and receiver stalls
   int stall_left = 0;
   int holds_done = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (stat_q.size() == 0) begin
               report_mismatch("unexpected result", rsp_tdata, 0);
            end else begin
               row_stat_type w;
               w = stat_q.pop_front();
               if (rsp_tdata !== w.value) report_mismatch("stat_value", rsp_tdata, w.value);
               if (rsp_tuser !== w.err) report_mismatch("div_error", rsp_tuser, w.err);
            end
         end
         if (holds_done != hold_requests) begin
            holds_done <= holds_done + 1;
            stall_left <= 600;
            rsp_tready <= 0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 0;
         end else if (!quiet && $urandom_range(0, 11) == 0) begin
            stall_left <= $urandom_range(1, 9);
            rsp_tready <= 0;
         end else begin
            rsp_tready <= 1;
         end
         if (cycles > LIMIT_CYCLES) begin
            $display("timeout");
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task automatic csr_write(logic [CSR_INDEX_BITS-1:0] idx, logic [CORR_BITS-1:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_STAT_MODE) mode_mirror = val[MODE_BITS-1:0];
      else if (idx == CSR_DOF_CORR) corr_mirror = val;
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (sample_q.size() != 0 || req_tvalid || stat_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic push_row(int len);
      for (int i = 0; i < len; i++) begin
         sample_req_type it;
         it.sample = pick_sample();
         it.row_end = (i == len - 1);
         sample_q.push_back(it);
      end
   endtask

   task automatic push_sample(logic [15:0] s, logic last);
      sample_req_type it;
      it.sample = s;
      it.row_end = last;
      sample_q.push_back(it);
   endtask

   task automatic set_config(logic [MODE_BITS-1:0] m, logic [CORR_BITS-1:0] c);
      csr_write(CSR_STAT_MODE, CORR_BITS'(m));
      csr_write(CSR_DOF_CORR, c);
   endtask

   task automatic random_phase(int rows, int max_len);
      for (int r = 0; r < rows; r++)
         push_row($urandom_range(0, 9) == 0 ? $urandom_range(1, 3 * max_len)
                                             : $urandom_range(1, max_len));
   endtask

   initial begin
      logic [MODE_BITS-1:0] m;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset config: sum mode, extremes
      push_sample(16'h8000, 1);
      push_sample(16'h7fff, 1);
      push_sample(16'h8000, 0);
      push_sample(16'h8000, 0);
      push_sample(16'h7fff, 1);
      wait_drained();

      // mean truncation toward zero
      set_config(MODE_MEAN, 12'd0);
      push_sample(16'hffff, 0);
      push_sample(16'hfffe, 0);
      push_sample(16'h0000, 1);
      push_sample(16'h0007, 0);
      push_sample(16'h0000, 1);
      push_sample(16'h7fff, 1);
      wait_drained();

      // variance: too few elements, and enough
      set_config(MODE_VAR, 12'd1);
      push_sample(16'h1234, 1);
      push_sample(16'h8000, 0);
      push_sample(16'h7fff, 1);
      wait_drained();
      csr_write(2'd2, 12'hfff);
      csr_write(2'd3, 12'h000);
      set_config(MODE_VAR, 12'd0);
      push_sample(16'h8000, 1);
      push_sample(16'h0100, 0);
      push_sample(16'hff00, 0);
      push_sample(16'h8000, 1);
      wait_drained();

      // reserved mode
      set_config(2'd3, 12'h5a5);
      push_sample(16'h4000, 0);
      push_sample(16'h4000, 1);
      wait_drained();

      // long rows, largest correction and none
      set_config(MODE_VAR, 12'd4095);
      push_row(200);
      push_row(3);
      wait_drained();
      set_config(MODE_VAR, 12'd0);
      push_row(500);
      wait_drained();
      set_config(MODE_SUM, 12'd0);
      for (int i = 0; i < 200; i++) push_sample(16'h8000, i == 199);
      wait_drained();

      // random phases; receiver holds off once while rows keep coming
      for (int p = 0; p < 12; p++) begin
         m = MODE_BITS'(p % 4);
         case (p % 3)
            0: set_config(m, CORR_BITS'($urandom_range(0, 3)));
            1: set_config(m, CORR_BITS'($urandom_range(0, 4095)));
            default: set_config(m, 12'hfff);
         endcase
         if (p == 11) quiet = 1;
         random_phase(12, 8);
         if (p == 2) hold_requests++;
         wait_drained();
      end

      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
